FILE: hw/rtl/ula_pkg.sv
// Shared types and constants for the ping-pong line assembler.
package ula_pkg;

  // Default number of byte positions in one line slot.
  localparam int LINE_CAPACITY = 64;

  // Width of the character count reported on take results.
  localparam int COUNT_W = 6;

  // Depth of the operation queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Character codes.
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7E;

  // Request action code for a take of the completed line.
  localparam logic ACT_TAKE = 1'b1;

  typedef enum logic [1:0] {
    KIND_ECHO  = 2'd0,
    KIND_CHAR  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
    logic [6:0] max_len;
  } req_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         data_byte;
    logic               last;
    logic               line_ready;
    logic               overflow_seen;
    logic [COUNT_W-1:0] count;
  } res_t;

  typedef enum logic [1:0] {
    OP_TAKE,
    OP_EOL,
    OP_PRINT,
    OP_CTRL
  } op_class_t;

  // Decoded operation handed from the front to the back.
  typedef struct packed {
    op_class_t          cls;
    logic               is_cr;
    logic               is_lf;
    logic [7:0]         ch;
    logic [COUNT_W-1:0] limit;
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LF,
    BK_TAKE
  } back_state_t;

endpackage

FILE: hw/rtl/uart_line_assembler_ping_pong_core.sv
// Top level of the ping-pong line assembler.
//
// Requests enter on start/request: a transfer happens at a rising edge where
// start is high and busy is low. A request either carries one received UART
// byte (action 0) or asks to take the completed command line (action 1).
// Each result is shown on result for exactly one cycle, marked by strobe;
// the receiver cannot hold results off, so every strobed cycle is a transfer.
// Results of one request are contiguous and the final one has last set.
//
// A front stage decodes each request into a small operation queue; busy is
// high only while that two-entry queue is full. The back end serves one
// operation at a time. The first result of a byte passes the queue entry and
// the result register. A byte is handled in the idle state, a line end in the
// idle and LF states (CR echo, then LF echo carrying line_ready). A take is
// answered empty from the idle state, or set up there and then read out in
// the take state, each character from the line buffer memory through its
// single registered read port. Bytes arriving far apart never see busy.
//
// Synchronous reset empties the queue, frees both slots and clears the
// overflow flag; line buffer contents are left as they were.
module uart_line_assembler_ping_pong_core #(
  parameter int LINE_CAPACITY = ula_pkg::LINE_CAPACITY
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ula_pkg::req_t request,
  output logic          strobe,
  output ula_pkg::res_t result
);

  logic         push;
  logic         pop;
  logic         q_empty;
  logic         q_full;
  ula_pkg::op_t op_front;
  ula_pkg::op_t op_head;

  assign busy = q_full;

  ula_front u_front (
    .start   (start),
    .full    (q_full),
    .request (request),
    .push    (push),
    .op      (op_front)
  );

  ula_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .op_in  (op_front),
    .pop    (pop),
    .op_out (op_head),
    .empty  (q_empty),
    .full   (q_full)
  );

  ula_back #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .op      (op_head),
    .pop     (pop),
    .strobe  (strobe),
    .result  (result)
  );

endmodule

FILE: hw/rtl/ula_front.sv
// Front end: accepts requests and classifies them into queue operations.
module ula_front (
  input  logic          start,
  input  logic          full,
  input  ula_pkg::req_t request,
  output logic          push,
  output ula_pkg::op_t  op
);

  logic [6:0] lim_raw;

  assign push = start && !full;

  always_comb begin
    lim_raw  = (request.max_len == 7'd0) ? 7'd0 : request.max_len - 7'd1;
    op.ch    = request.rx_byte;
    op.is_cr = (request.rx_byte == ula_pkg::CH_CR);
    op.is_lf = (request.rx_byte == ula_pkg::CH_LF);
    // A slot never holds more than the count field can express.
    op.limit = lim_raw[6] ? {ula_pkg::COUNT_W{1'b1}} : lim_raw[ula_pkg::COUNT_W-1:0];
    priority if (request.action == ula_pkg::ACT_TAKE) begin
      op.cls = ula_pkg::OP_TAKE;
    end else if (op.is_cr || op.is_lf) begin
      op.cls = ula_pkg::OP_EOL;
    end else if (request.rx_byte >= ula_pkg::PRINT_LO &&
                 request.rx_byte <= ula_pkg::PRINT_HI) begin
      op.cls = ula_pkg::OP_PRINT;
    end else begin
      op.cls = ula_pkg::OP_CTRL;
    end
  end

endmodule

FILE: hw/rtl/ula_queue.sv
// Short FIFO of decoded operations between the front and the back.
module ula_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  ula_pkg::op_t op_in,
  input  logic         pop,
  output ula_pkg::op_t op_out,
  output logic         empty,
  output logic         full
);

  ula_pkg::op_t                 entries [ula_pkg::QUEUE_DEPTH];
  logic [ula_pkg::QPTR_W-1:0]   wr_ptr;
  logic [ula_pkg::QPTR_W-1:0]   rd_ptr;
  logic [ula_pkg::QPTR_W:0]     used;

  assign empty  = (used == '0);
  assign full   = (used == (ula_pkg::QPTR_W+1)'(ula_pkg::QUEUE_DEPTH));
  assign op_out = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + ula_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + ula_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        used <= used + (ula_pkg::QPTR_W+1)'(1);
      end else if (pop && !push) begin
        used <= used - (ula_pkg::QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= op_in;
    end
  end

endmodule

FILE: hw/rtl/ula_back.sv
// Back end: slot bookkeeping, line buffer memory and result sequencing.
module ula_back #(
  parameter int LINE_CAPACITY = ula_pkg::LINE_CAPACITY
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  ula_pkg::op_t  op,
  output logic          pop,
  output logic          strobe,
  output ula_pkg::res_t result
);

  localparam int LEN_W = $clog2(LINE_CAPACITY);
  localparam int AW    = LEN_W + 1;
  localparam int DEPTH = 2 ** AW;
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(LINE_CAPACITY - 1);

  ula_pkg::back_state_t state, state_next;

  logic [7:0]       mem [DEPTH];
  logic [7:0]       rd_data;

  logic [LEN_W-1:0] len_slot0;
  logic [LEN_W-1:0] len_slot1;
  logic [1:0]       slot_complete;
  logic             fill_index;
  logic             ready_index;
  logic             overflow_flag;
  logic             after_cr;

  logic             take_idx;
  logic [LEN_W-1:0] take_n;
  logic [LEN_W-1:0] take_ptr;
  logic             take_ovf;

  logic                       out_strobe;
  ula_pkg::kind_t             out_kind;
  logic [7:0]                 out_byte;
  logic                       out_last;
  logic                       out_ready;
  logic                       out_ovf;
  logic [ula_pkg::COUNT_W-1:0] out_count;
  logic                       out_mem;

  // Decisions for the operation at the queue head.
  logic             is_take;
  logic             drop_lf;
  logic             line_end;
  logic             byte_data;
  logic [LEN_W-1:0] fill_len;
  logic             fill_blocked;
  logic             store;
  logic             mark_ovf;
  logic             hit;
  logic             sel;
  logic [LEN_W-1:0] sel_len;
  logic [LEN_W-1:0] n;
  logic             take_stream;
  logic             take_last;

  logic                        emit;
  ula_pkg::kind_t              e_kind;
  logic [7:0]                  e_byte;
  logic                        e_last;
  logic                        e_ready;
  logic                        e_ovf;
  logic [ula_pkg::COUNT_W-1:0] e_count;
  logic                        e_mem;

  always_comb begin
    pop          = (state == ula_pkg::BK_IDLE) && !q_empty;
    is_take      = (op.cls == ula_pkg::OP_TAKE);
    drop_lf      = !is_take && op.is_lf && after_cr;
    line_end     = !drop_lf && (op.cls == ula_pkg::OP_EOL);
    byte_data    = (op.cls == ula_pkg::OP_PRINT) || (op.cls == ula_pkg::OP_CTRL);
    fill_len     = fill_index ? len_slot1 : len_slot0;
    fill_blocked = slot_complete[fill_index] || (fill_len == LEN_FULL);
    store        = pop && byte_data && !fill_blocked;
    mark_ovf     = pop && byte_data && fill_blocked;
    // The ready slot is tried first, then the slot that is not filling.
    if (slot_complete[ready_index]) begin
      hit = 1'b1;
      sel = ready_index;
    end else if (slot_complete[!fill_index]) begin
      hit = 1'b1;
      sel = !fill_index;
    end else begin
      hit = 1'b0;
      sel = ready_index;
    end
    sel_len     = sel ? len_slot1 : len_slot0;
    n           = (ula_pkg::COUNT_W'(sel_len) > op.limit) ? LEN_W'(op.limit) : sel_len;
    take_stream = pop && is_take && hit && (n != '0);
    take_last   = (take_ptr == take_n - LEN_W'(1));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ula_pkg::BK_IDLE: begin
        if (pop && !is_take && line_end) begin
          state_next = ula_pkg::BK_LF;
        end else if (take_stream) begin
          state_next = ula_pkg::BK_TAKE;
        end
      end
      ula_pkg::BK_LF: begin
        state_next = ula_pkg::BK_IDLE;
      end
      ula_pkg::BK_TAKE: begin
        if (take_last) begin
          state_next = ula_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = ula_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    emit    = 1'b0;
    e_kind  = ula_pkg::KIND_ECHO;
    e_byte  = 8'd0;
    e_last  = 1'b0;
    e_ready = 1'b0;
    e_ovf   = 1'b0;
    e_count = '0;
    e_mem   = 1'b0;
    unique case (state)
      ula_pkg::BK_IDLE: begin
        if (pop && is_take) begin
          if (!take_stream) begin
            emit   = 1'b1;
            e_kind = ula_pkg::KIND_EMPTY;
            e_last = 1'b1;
            e_ovf  = overflow_flag;
          end
        end else if (pop && line_end) begin
          emit   = 1'b1;
          e_byte = ula_pkg::CH_CR;
        end else if (pop && op.cls == ula_pkg::OP_PRINT) begin
          emit   = 1'b1;
          e_byte = op.ch;
          e_last = 1'b1;
        end
      end
      ula_pkg::BK_LF: begin
        emit    = 1'b1;
        e_byte  = ula_pkg::CH_LF;
        e_last  = 1'b1;
        e_ready = 1'b1;
      end
      ula_pkg::BK_TAKE: begin
        emit    = 1'b1;
        e_kind  = ula_pkg::KIND_CHAR;
        e_last  = take_last;
        e_ovf   = take_ovf;
        e_count = ula_pkg::COUNT_W'(take_n);
        e_mem   = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ula_pkg::BK_IDLE;
      len_slot0     <= '0;
      len_slot1     <= '0;
      slot_complete <= '0;
      fill_index    <= 1'b0;
      ready_index   <= 1'b0;
      overflow_flag <= 1'b0;
      after_cr      <= 1'b0;
      take_ptr      <= '0;
      out_strobe    <= 1'b0;
    end else begin
      state      <= state_next;
      out_strobe <= emit;
      if (pop && is_take) begin
        overflow_flag <= 1'b0;
        if (hit) begin
          slot_complete[sel] <= 1'b0;
          if (sel) begin
            len_slot1 <= '0;
          end else begin
            len_slot0 <= '0;
          end
        end
        take_ptr <= '0;
      end else if (mark_ovf) begin
        overflow_flag <= 1'b1;
      end
      if (pop && !is_take) begin
        after_cr <= drop_lf ? 1'b0 : op.is_cr;
      end
      if (pop && line_end) begin
        // Close the filling slot and start over in the other one.
        slot_complete[fill_index]  <= 1'b1;
        slot_complete[!fill_index] <= 1'b0;
        ready_index                <= fill_index;
        fill_index                 <= !fill_index;
        if (fill_index) begin
          len_slot0 <= '0;
        end else begin
          len_slot1 <= '0;
        end
      end
      if (store) begin
        if (fill_index) begin
          len_slot1 <= fill_len + LEN_W'(1);
        end else begin
          len_slot0 <= fill_len + LEN_W'(1);
        end
      end
      if (state == ula_pkg::BK_TAKE) begin
        take_ptr <= take_ptr + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_take) begin
      take_idx <= sel;
      take_n   <= n;
      take_ovf <= overflow_flag;
    end
    out_kind  <= e_kind;
    out_byte  <= e_byte;
    out_last  <= e_last;
    out_ready <= e_ready;
    out_ovf   <= e_ovf;
    out_count <= e_count;
    out_mem   <= e_mem;
  end

  always_ff @(posedge clk) begin
    if (store) begin
      mem[{fill_index, fill_len}] <= op.ch;
    end
    if (state == ula_pkg::BK_TAKE) begin
      rd_data <= mem[{take_idx, take_ptr}];
    end
  end

  assign strobe               = out_strobe;
  assign result.kind          = out_kind;
  assign result.data_byte     = out_mem ? rd_data : out_byte;
  assign result.last          = out_last;
  assign result.line_ready    = out_ready;
  assign result.overflow_seen = out_ovf;
  assign result.count         = out_count;

endmodule

FILE: hw/rtl/ula_checker.sv
// Port-level checks for the ping-pong line assembler, bound to the top level.
module ula_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input ula_pkg::req_t request,
  input logic          strobe,
  input ula_pkg::res_t result
);

  // No result leaves the block in the cycle after a reset edge.
  a_quiet_after_reset : assert property (@(posedge clk)
    rst |=> !strobe)
    else $error("result strobed right after reset");

  // A request taken by the block carries known values.
  a_request_known : assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> !$isunknown(request))
    else $error("request transfer with unknown fields");

  // A take streams its characters in consecutive cycles with a steady count.
  a_take_stream : assert property (@(posedge clk) disable iff (rst)
    strobe && result.kind == ula_pkg::KIND_CHAR && !result.last |=>
      strobe && result.kind == ula_pkg::KIND_CHAR &&
      result.count == $past(result.count))
    else $error("take stream broken");

  // The line-ready LF echo directly follows the CR echo.
  a_lf_after_cr : assert property (@(posedge clk) disable iff (rst)
    strobe && result.line_ready |->
      $past(strobe) && $past(result.data_byte) == ula_pkg::CH_CR &&
      result.data_byte == ula_pkg::CH_LF && result.last)
    else $error("line ready without preceding CR echo");

  // Echo results carry no take status.
  a_echo_clean : assert property (@(posedge clk) disable iff (rst)
    strobe && result.kind == ula_pkg::KIND_ECHO |->
      result.count == '0 && !result.overflow_seen)
    else $error("echo result carries take status");

endmodule

bind uart_line_assembler_ping_pong_core ula_checker u_ula_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .strobe  (strobe),
  .result  (result)
);
